FILE: design/hash_key_index_table_unit_macros.svh
// Assertion macros for the hash key index table unit.
// Depends on clk and arst_n being visible at the point of use.
`ifndef HASH_KEY_INDEX_TABLE_UNIT_MACROS_SVH
`define HASH_KEY_INDEX_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define HKIT_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);
`define HKIT_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define HKIT_ASSERT_IMP(label, cond, prop, msg)
`define HKIT_ASSERT_NXT(label, cond, prop, msg)
`endif
`endif

FILE: design/hkit_pkg.sv
// Shared types and constants for the hash key index table unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hkit_pkg;
	localparam int MAX_SLOTS_LOG2 = 12;
	localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h01000193;
	localparam int FOLD_SHIFT = 15;
	localparam int KEY_BYTES = 32;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_PUT = 2'd1;
	localparam logic [1:0] CMD_GET = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_FOUND = 3'd3;
	localparam logic [2:0] ST_ABSENT = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	typedef struct packed {
		logic valid;
		logic [255:0] key;
		logic [31:0] height;
	} slot_t;

	typedef enum logic [4:0] {
		S_CLR = 5'b00001,
		S_IDLE = 5'b00010,
		S_HASH = 5'b00100,
		S_RD = 5'b01000,
		S_CMP = 5'b10000
	} state_t;
endpackage
`default_nettype wire

FILE: design/hkit_hash.sv
// FNV-1a 32 hash over a 32-byte key, one byte per cycle, then folded.
// Depends on hkit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hkit_hash (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [255:0] key,
	output logic done,
	output logic [31:0] hash
);
	logic [255:0] key_q;
	logic [31:0] h_q;
	logic [4:0] cnt_q;
	logic run_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 5'(hkit_pkg::KEY_BYTES - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(hkit_pkg::KEY_BYTES - 1)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			h_q <= hkit_pkg::FNV_BASIS;
		end else if (run_q) begin
			key_q <= key_q >> 8;
			h_q <= 32'((h_q ^ {24'd0, key_q[7:0]}) * hkit_pkg::FNV_PRIME);
		end
	end

	assign done = done_q;
	assign hash = h_q ^ (h_q >> hkit_pkg::FOLD_SHIFT);
endmodule
`default_nettype wire

FILE: design/hkit_mem.sv
// Slot memory: one read/write port, registered read data.
// Depends on hkit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hkit_mem #(
	parameter int AW = hkit_pkg::MAX_SLOTS_LOG2
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] addr,
	input wire hkit_pkg::slot_t wdata,
	output hkit_pkg::slot_t rdata
);
	hkit_pkg::slot_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: design/hash_key_index_table_unit.sv
// Top level of the hash key index table unit: sequencer, hash and slot memory.
// Depends on hkit_pkg, hkit_hash, hkit_mem and the macros header.
//
// channel | signals                                      | handshake
// request | command key_w0..3 height_in                  | start & !busy
// result  | status height_out entry_count                | done, one cycle
// config  | cfg_wdata                                    | cfg_we
//
// Clear writes all 2^MAX_SLOTS_LOG2 slots, one slot written per cycle.
// Put/get hash the key, then probe slots in turn, each probe a read state then a compare state.
// Command three is answered in the cycle after start, with status absent.
// Reset runs the same clearing pass with busy high.
// Results cannot be stalled; done marks each for one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "hash_key_index_table_unit_macros.svh"
module hash_key_index_table_unit #(
	parameter int MAX_SLOTS_LOG2 = hkit_pkg::MAX_SLOTS_LOG2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] command,
	input wire logic [63:0] key_w0,
	input wire logic [63:0] key_w1,
	input wire logic [63:0] key_w2,
	input wire logic [63:0] key_w3,
	input wire logic [31:0] height_in,
	input wire logic cfg_we,
	input wire logic [3:0] cfg_wdata,
	output logic done,
	output logic [2:0] status,
	output logic [31:0] height_out,
	output logic [12:0] entry_count
);
	localparam int AW = MAX_SLOTS_LOG2;
	localparam int LW = $clog2(MAX_SLOTS_LOG2 + 1);
	localparam int CW = MAX_SLOTS_LOG2 + 1;

	hkit_pkg::state_t state_q;
	logic [LW-1:0] log2_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] clr_idx_q;
	logic report_q;
	logic [AW-1:0] slot_q;
	logic [CW-1:0] budget_q;
	logic [1:0] cmd_q;
	logic [255:0] key_q;
	logic [31:0] height_q;
	logic done_q;
	logic [2:0] status_q;
	logic [31:0] hout_q;

	logic [LW+3:0] cfg_ext;
	logic [CW-1:0] mask_full;
	logic [AW-1:0] mask;
	logic hash_start;
	logic hash_done;
	logic [31:0] hash;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	hkit_pkg::slot_t mem_wdata;
	hkit_pkg::slot_t mem_rdata;
	logic hit;
	logic [CW+12:0] count_ext;

	assign cfg_ext = (LW + 4)'(cfg_wdata);
	assign mask_full = CW'((CW'(1) << log2_q) - CW'(1));
	assign mask = mask_full[AW-1:0];
	assign hash_start = (state_q == hkit_pkg::S_IDLE) && start
		&& (command == hkit_pkg::CMD_PUT || command == hkit_pkg::CMD_GET);
	assign hit = mem_rdata.key == key_q;

	assign mem_addr = (state_q == hkit_pkg::S_CLR) ? clr_idx_q : slot_q;
	assign mem_we = (state_q == hkit_pkg::S_CLR)
		|| ((state_q == hkit_pkg::S_CMP) && (cmd_q == hkit_pkg::CMD_PUT) && !mem_rdata.valid);
	assign mem_wdata = (state_q == hkit_pkg::S_CLR) ? hkit_pkg::slot_t'('0)
		: hkit_pkg::slot_t'{valid: 1'b1, key: key_q, height: height_q};

	hkit_hash u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.start(hash_start),
		.key({key_w3, key_w2, key_w1, key_w0}),
		.done(hash_done),
		.hash(hash)
	);

	hkit_mem #(.AW(AW)) u_mem (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q <= LW'(12 > MAX_SLOTS_LOG2 ? MAX_SLOTS_LOG2 : 12);
		end else if (cfg_we) begin
			if (cfg_ext > (LW + 4)'(MAX_SLOTS_LOG2)) log2_q <= LW'(MAX_SLOTS_LOG2);
			else log2_q <= LW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hkit_pkg::S_CLR;
			clr_idx_q <= '0;
			report_q <= 1'b0;
			count_q <= '0;
			done_q <= 1'b0;
			status_q <= hkit_pkg::ST_ABSENT;
			hout_q <= '0;
			slot_q <= '0;
			budget_q <= '0;
			cmd_q <= hkit_pkg::CMD_CLEAR;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				hkit_pkg::S_CLR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == '1) begin
						state_q <= hkit_pkg::S_IDLE;
						count_q <= '0;
						if (report_q) begin
							done_q <= 1'b1;
							status_q <= hkit_pkg::ST_CLEARED;
							hout_q <= '0;
						end
					end
				end
				hkit_pkg::S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						case (command)
							hkit_pkg::CMD_CLEAR: begin
								state_q <= hkit_pkg::S_CLR;
								clr_idx_q <= '0;
								report_q <= 1'b1;
							end
							hkit_pkg::CMD_PUT, hkit_pkg::CMD_GET: state_q <= hkit_pkg::S_HASH;
							default: begin
								done_q <= 1'b1;
								status_q <= hkit_pkg::ST_ABSENT;
								hout_q <= '0;
							end
						endcase
					end
				end
				hkit_pkg::S_HASH: begin
					if (hash_done) begin
						slot_q <= hash[AW-1:0] & mask;
						budget_q <= CW'({1'b0, mask} + CW'(1));
						state_q <= hkit_pkg::S_RD;
					end
				end
				hkit_pkg::S_RD: state_q <= hkit_pkg::S_CMP;
				hkit_pkg::S_CMP: begin
					if (!mem_rdata.valid) begin
						state_q <= hkit_pkg::S_IDLE;
						done_q <= 1'b1;
						hout_q <= '0;
						if (cmd_q == hkit_pkg::CMD_PUT) begin
							count_q <= count_q + CW'(1);
							status_q <= hkit_pkg::ST_INSERTED;
						end else begin
							status_q <= hkit_pkg::ST_ABSENT;
						end
					end else if (hit) begin
						state_q <= hkit_pkg::S_IDLE;
						done_q <= 1'b1;
						if (cmd_q == hkit_pkg::CMD_PUT) begin
							status_q <= hkit_pkg::ST_DUPLICATE;
							hout_q <= '0;
						end else begin
							status_q <= hkit_pkg::ST_FOUND;
							hout_q <= mem_rdata.height;
						end
					end else if (budget_q == CW'(1)) begin
						state_q <= hkit_pkg::S_IDLE;
						done_q <= 1'b1;
						hout_q <= '0;
						status_q <= (cmd_q == hkit_pkg::CMD_PUT) ? hkit_pkg::ST_FULL
							: hkit_pkg::ST_ABSENT;
					end else begin
						budget_q <= budget_q - CW'(1);
						slot_q <= (slot_q + AW'(1)) & mask;
						state_q <= hkit_pkg::S_RD;
					end
				end
				default: state_q <= hkit_pkg::S_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hash_start) begin
			key_q <= {key_w3, key_w2, key_w1, key_w0};
			height_q <= height_in;
		end
	end

	assign count_ext = {13'd0, count_q};
	assign busy = state_q != hkit_pkg::S_IDLE;
	assign done = done_q;
	assign status = status_q;
	assign height_out = hout_q;
	assign entry_count = count_ext[12:0];

	`HKIT_ASSERT_NXT(a_clear_busy, start && !busy && command == hkit_pkg::CMD_CLEAR, busy, "clear did not raise busy")
	`HKIT_ASSERT_IMP(a_clear_zero, done && status == hkit_pkg::ST_CLEARED, entry_count == 13'd0, "count not zero after clear")
	`HKIT_ASSERT_IMP(a_height_zero, done && status != hkit_pkg::ST_FOUND, height_out == 32'd0, "height nonzero without hit")
	`HKIT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(2 ** AW), "live count above table depth")
endmodule
`default_nettype wire
